/* hw/rtl/gbs_pkg.sv */
// shared types and constants for the greedy box suppression block
// no dependencies
package gbs_pkg;

  localparam int unsigned MAX_BOXES  = 64;
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned SIZE_BITS  = COORD_BITS + 1;
  localparam int unsigned IDX_W      = $clog2(MAX_BOXES);
  localparam int unsigned CNT_W      = $clog2(MAX_BOXES + 1);
  localparam int unsigned AREA_W     = 2 * SIZE_BITS;
  localparam int unsigned UNI_W      = AREA_W + 1;
  localparam int unsigned BOX_W      = 2 * COORD_BITS + 2 * SIZE_BITS + 32;
  localparam int unsigned TDATA_W    = ((BOX_W + 7) / 8) * 8;
  localparam int unsigned CFG_W      = 8;

  // overlap test pipeline depth, from read data to compare result
  localparam int unsigned PIPE_LAT   = 4;

  localparam logic CFG_NUM = 1'b0;
  localparam logic CFG_DEN = 1'b1;

  typedef struct packed {
    logic [15:0]           tag;
    logic signed [15:0]    score;
    logic [SIZE_BITS-1:0]  h;
    logic [SIZE_BITS-1:0]  w;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } box_t;

  typedef struct packed {
    logic             ld_nb;
    logic             ld_ref;
    logic             ld_out;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_sel_nb;
  } gbs_cmd_t;

  typedef struct packed {
    logic score_lt;
    logic suppress;
  } gbs_sts_t;

endpackage

/* hw/rtl/gbs_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module gbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* hw/rtl/gbs_datapath.sv */
// box store, overlap test pipeline, threshold registers and output register
// depends on gbs_pkg and gbs_ram
module gbs_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [gbs_pkg::CFG_W-1:0]   cfg_data_i,
  input  gbs_pkg::box_t               in_box_i,
  input  gbs_pkg::gbs_cmd_t           cmd_i,
  output gbs_pkg::gbs_sts_t           sts_o,
  output gbs_pkg::box_t               out_box_o
);

  localparam int unsigned SB = gbs_pkg::SIZE_BITS;
  localparam int unsigned EW = SB + 1;

  logic [gbs_pkg::CFG_W-1:0] num_q, den_q;
  gbs_pkg::box_t nb_q, ref_q, out_q, rd_box, wr_box;
  logic [gbs_pkg::BOX_W-1:0] rd_data;
  logic [gbs_pkg::AREA_W-1:0] ai_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= gbs_pkg::CFG_W'(2);
      den_q <= gbs_pkg::CFG_W'(5);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gbs_pkg::CFG_NUM: num_q <= cfg_data_i;
        gbs_pkg::CFG_DEN: den_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign wr_box = cmd_i.wr_sel_nb ? nb_q : rd_box;
  assign rd_box = gbs_pkg::box_t'(rd_data);

  gbs_ram #(
    .WIDTH (gbs_pkg::BOX_W),
    .DEPTH (gbs_pkg::MAX_BOXES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i (wr_box),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_nb)  nb_q  <= in_box_i;
    if (cmd_i.ld_ref) ref_q <= rd_box;
    if (cmd_i.ld_out) out_q <= rd_box;
    ai_q <= ref_q.w * ref_q.h;
  end

  assign sts_o.score_lt = $signed(rd_box.score) < $signed(nb_q.score);
  assign out_box_o = out_q;

  // stage 1: overlap extents and area of the stored box
  logic [EW-1:0] ax2, bx2, ay2, by2, lx, rx, ly, ry;
  logic [SB-1:0] dx_q, dy_q;
  logic [gbs_pkg::AREA_W-1:0] aj_q;
  logic ne1_q, ne2_q, ne3_q, ne4_q;

  always_comb begin
    ax2 = EW'(ref_q.x) + EW'(ref_q.w);
    bx2 = EW'(rd_box.x) + EW'(rd_box.w);
    ay2 = EW'(ref_q.y) + EW'(ref_q.h);
    by2 = EW'(rd_box.y) + EW'(rd_box.h);
    lx  = (ref_q.x > rd_box.x) ? EW'(ref_q.x) : EW'(rd_box.x);
    ly  = (ref_q.y > rd_box.y) ? EW'(ref_q.y) : EW'(rd_box.y);
    rx  = (ax2 < bx2) ? ax2 : bx2;
    ry  = (ay2 < by2) ? ay2 : by2;
  end

  logic [EW-1:0] dxf, dyf;
  assign dxf = rx - lx;
  assign dyf = ry - ly;

  // stages 2 to 4: intersection, union, cross multiplied threshold
  logic [gbs_pkg::AREA_W-1:0] inter2_q, inter3_q;
  logic [gbs_pkg::UNI_W-1:0]  asum_q, uni_q;
  logic [gbs_pkg::AREA_W+gbs_pkg::CFG_W-1:0] lhs_q;
  logic [gbs_pkg::UNI_W+gbs_pkg::CFG_W-1:0]  rhs_q;

  always_ff @(posedge clk_i) begin
    dx_q     <= dxf[SB-1:0];
    dy_q     <= dyf[SB-1:0];
    ne1_q    <= (rx > lx) && (ry > ly);
    aj_q     <= rd_box.w * rd_box.h;
    inter2_q <= dx_q * dy_q;
    asum_q   <= gbs_pkg::UNI_W'(ai_q) + gbs_pkg::UNI_W'(aj_q);
    ne2_q    <= ne1_q;
    uni_q    <= asum_q - gbs_pkg::UNI_W'(inter2_q);
    inter3_q <= inter2_q;
    ne3_q    <= ne2_q;
    lhs_q    <= inter3_q * den_q;
    rhs_q    <= uni_q * num_q;
    ne4_q    <= ne3_q;
  end

  assign sts_o.suppress = ne4_q &&
    ((gbs_pkg::UNI_W + gbs_pkg::CFG_W)'(lhs_q) > rhs_q);

endmodule

/* hw/rtl/gbs_ctrl.sv */
// sequencer for loading, sorted insertion, suppression and emission
// depends on gbs_pkg
module gbs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              out_last_o,
  output logic              out_dropped_o,
  input  gbs_pkg::gbs_sts_t sts_i,
  output gbs_pkg::gbs_cmd_t cmd_o
);

  localparam int unsigned CW = gbs_pkg::CNT_W;
  localparam int unsigned IW = gbs_pkg::IDX_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_CHK = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_INS_END = 4'd3;
  localparam logic [3:0] S_SUP_LD  = 4'd4;
  localparam logic [3:0] S_SUP_LDW = 4'd5;
  localparam logic [3:0] S_SUP_J   = 4'd6;
  localparam logic [3:0] S_SUP_W   = 4'd7;
  localparam logic [3:0] S_EM_CHK  = 4'd8;
  localparam logic [3:0] S_EM_RD   = 4'd9;
  localparam logic [3:0] S_EM_WAIT = 4'd10;
  localparam logic [3:0] S_CLR     = 4'd11;

  logic [3:0] state_q, state_d;
  logic [CW-1:0] count_q, count_d, pos_q, pos_d, i_q, i_d, j_q, j_d, lk_q, lk_d;
  logic [2:0] wcnt_q, wcnt_d;
  logic last_q, last_d, ovf_q, ovf_d, keep_q, keep_d;
  logic ov_q, ov_d, ol_q, ol_d;
  logic [gbs_pkg::MAX_BOXES-1:0] marks_q, marks_d;
  logic [CW-1:0] pos_m1;

  assign pos_m1 = pos_q - CW'(1);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pos_d   = pos_q;
    i_d     = i_q;
    j_d     = j_q;
    lk_d    = lk_q;
    wcnt_d  = wcnt_q;
    last_d  = last_q;
    ovf_d   = ovf_q;
    keep_d  = keep_q;
    ov_d    = ov_q;
    ol_d    = ol_q;
    marks_d = marks_q;
    cmd_o   = '0;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d = in_last_i;
          if (count_q < CW'(gbs_pkg::MAX_BOXES)) begin
            cmd_o.ld_nb = 1'b1;
            pos_d   = count_q;
            state_d = S_INS_CHK;
          end else begin
            ovf_d = 1'b1;
            if (in_last_i) begin
              i_d     = '0;
              state_d = S_SUP_LD;
            end
          end
        end
      end
      S_INS_CHK: begin
        if (pos_q == '0) begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.wr_sel_nb = 1'b1;
          cmd_o.wr_addr   = pos_q[IW-1:0];
          state_d = S_INS_END;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = pos_m1[IW-1:0];
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = pos_q[IW-1:0];
        if (sts_i.score_lt) begin
          pos_d   = pos_m1;
          state_d = S_INS_CHK;
        end else begin
          cmd_o.wr_sel_nb = 1'b1;
          state_d = S_INS_END;
        end
      end
      S_INS_END: begin
        count_d = count_q + CW'(1);
        i_d     = '0;
        state_d = last_q ? S_SUP_LD : S_IDLE;
      end
      S_SUP_LD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = i_q[IW-1:0];
        state_d = S_SUP_LDW;
      end
      S_SUP_LDW: begin
        cmd_o.ld_ref = 1'b1;
        j_d     = '0;
        keep_d  = 1'b1;
        state_d = S_SUP_J;
      end
      S_SUP_J: begin
        if ((j_q == i_q) || !keep_q) begin
          marks_d[i_q[IW-1:0]] = keep_q;
          if (keep_q) lk_d = i_q;
          i_d = i_q + CW'(1);
          if (i_q + CW'(1) == count_q) begin
            i_d     = '0;
            state_d = S_EM_CHK;
          end else begin
            state_d = S_SUP_LD;
          end
        end else if (!marks_q[j_q[IW-1:0]]) begin
          j_d = j_q + CW'(1);
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = j_q[IW-1:0];
          wcnt_d  = '0;
          state_d = S_SUP_W;
        end
      end
      S_SUP_W: begin
        if (wcnt_q == 3'(gbs_pkg::PIPE_LAT)) begin
          if (sts_i.suppress) keep_d = 1'b0;
          j_d     = j_q + CW'(1);
          state_d = S_SUP_J;
        end else begin
          wcnt_d = wcnt_q + 3'd1;
        end
      end
      S_EM_CHK: begin
        if (i_q == count_q) begin
          state_d = S_CLR;
        end else if (!marks_q[i_q[IW-1:0]]) begin
          i_d = i_q + CW'(1);
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = i_q[IW-1:0];
          state_d = S_EM_RD;
        end
      end
      S_EM_RD: begin
        cmd_o.ld_out = 1'b1;
        ov_d    = 1'b1;
        ol_d    = (i_q == lk_q);
        state_d = S_EM_WAIT;
      end
      S_EM_WAIT: begin
        if (out_ready_i) begin
          ov_d    = 1'b0;
          i_d     = i_q + CW'(1);
          state_d = S_EM_CHK;
        end
      end
      S_CLR: begin
        count_d = '0;
        ovf_d   = 1'b0;
        marks_d = '0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pos_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      lk_q    <= '0;
      wcnt_q  <= '0;
      last_q  <= 1'b0;
      ovf_q   <= 1'b0;
      keep_q  <= 1'b0;
      ov_q    <= 1'b0;
      ol_q    <= 1'b0;
      marks_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      i_q     <= i_d;
      j_q     <= j_d;
      lk_q    <= lk_d;
      wcnt_q  <= wcnt_d;
      last_q  <= last_d;
      ovf_q   <= ovf_d;
      keep_q  <= keep_d;
      ov_q    <= ov_d;
      ol_q    <= ol_d;
      marks_q <= marks_d;
    end
  end

  assign out_valid_o   = ov_q;
  assign out_last_o    = ol_q;
  assign out_dropped_o = ovf_q;

endmodule

/* hw/rtl/greedy_box_suppression.sv */
// top level of the greedy box suppression block
// depends on gbs_pkg, gbs_ctrl, gbs_datapath and gbs_ram
//
// usage:
//   candidate boxes enter on the s_axis channel, one item per handshake;
//   tlast marks the final box of a set. boxes are kept in a score ordered
//   store of MAX_BOXES entries; boxes arriving at a full store are dropped
//   and the dropped flag (m_axis_tuser) is set on every result of that set.
//   after the last box, each box is tested against every earlier kept box;
//   survivors leave on m_axis in descending score order, tlast on the final
//   one. overlap threshold num/den is written on the cfg port while idle.
// sequence:
//   insertion shifts each stored box with a lower score down one place,
//   each step a store read followed by a write, as the store read data
//   is registered; the new box is then written into the free slot.
//   suppression loads each box as the reference, then tests it in turn
//   against each earlier kept box (store read and the 4 stage overlap
//   multiply pipeline); emission reads each kept box into the output
//   register, skipping suppressed boxes; a stalled result holds there.
//   s_axis_tready is high only while the block is idle between boxes.
// reset:
//   clears the box count, overflow flag and keep marks; the threshold
//   returns to 2/5. the box store needs no clearing.
module greedy_box_suppression (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [gbs_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // box_x, box_y, box_w, box_h, box_score, box_tag, zero pad
  input  logic [gbs_pkg::TDATA_W-1:0]  s_axis_tdata,
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // kept_x, kept_y, kept_w, kept_h, kept_score, kept_tag, zero pad
  output logic [gbs_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic                         m_axis_tlast,
  // dropped_flag
  output logic                         m_axis_tuser
);

  gbs_pkg::gbs_cmd_t cmd;
  gbs_pkg::gbs_sts_t sts;
  gbs_pkg::box_t     out_box;

  gbs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_last_i     (s_axis_tlast),
    .in_ready_o    (s_axis_tready),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_last_o    (m_axis_tlast),
    .out_dropped_o (m_axis_tuser),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  gbs_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_box_i   (gbs_pkg::box_t'(s_axis_tdata[gbs_pkg::BOX_W-1:0])),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_box_o  (out_box)
  );

  assign m_axis_tdata = gbs_pkg::TDATA_W'(out_box);

  // no new box is taken while a result is on offer
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result is pending");

  // a result never vanishes without being taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // store writes never coincide with an accepted box
  a_no_wr_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> !cmd.wr_en && !cmd.rd_en)
    else $error("store access while idle");

endmodule

/* test/testbench.sv */
// self-checking testbench for the greedy box suppression block
// depends on gbs_pkg and the greedy_box_suppression rtl; drives both stream sides
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic [gbs_pkg::TDATA_W-1:0] data;
    logic                        last;
    logic                        drop;
  } kept_rec_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic                        cfg_idx_i = gbs_pkg::CFG_NUM;
  logic [gbs_pkg::CFG_W-1:0]   cfg_data_i = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [gbs_pkg::TDATA_W-1:0] s_axis_tdata = '0;
  logic                        s_axis_tlast = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [gbs_pkg::TDATA_W-1:0] m_axis_tdata;
  logic                        m_axis_tlast;
  logic                        m_axis_tuser;

  // predictor state
  gbs_pkg::box_t ranked_boxes[$];
  bit            set_overflow = 1'b0;
  int unsigned   thr_num = 2;
  int unsigned   thr_den = 5;
  kept_rec_t     kept_q[$];

  int          n_errors = 0;
  int          hold_cycles = 0;
  int          stall_left = 0;

  always #2 clk_i = ~clk_i;

  greedy_box_suppression i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  task automatic report_mismatch(input string what, input logic [127:0] got,
                                 input logic [127:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // exact iou test: inter*den > num*union
  function automatic bit too_close(gbs_pkg::box_t a, gbs_pkg::box_t b);
    longint unsigned ax2, bx2, ay2, by2, lx, ly, rx, ry, inter, uni;
    ax2 = a.x + a.w; bx2 = b.x + b.w;
    ay2 = a.y + a.h; by2 = b.y + b.h;
    lx = (a.x > b.x) ? a.x : b.x;
    ly = (a.y > b.y) ? a.y : b.y;
    rx = (ax2 < bx2) ? ax2 : bx2;
    ry = (ay2 < by2) ? ay2 : by2;
    if (rx <= lx || ry <= ly) return 1'b0;
    inter = (rx - lx) * (ry - ly);
    uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
    return inter * thr_den > longint'(thr_num) * uni;
  endfunction

  // rank insertion, then suppression and emission order on the last box
  task automatic predict_box(input gbs_pkg::box_t b, input bit is_last);
    int pos;
    bit keep[$];
    bit ok;
    int last_idx;
    kept_rec_t rec;
    if (ranked_boxes.size() < gbs_pkg::MAX_BOXES) begin
      pos = ranked_boxes.size();
      while (pos > 0 && $signed(ranked_boxes[pos-1].score) < $signed(b.score)) pos--;
      ranked_boxes.insert(pos, b);
    end else begin
      set_overflow = 1'b1;
    end
    if (!is_last) return;
    last_idx = 0;
    for (int i = 0; i < ranked_boxes.size(); i++) begin
      ok = 1'b1;
      for (int j = 0; j < i && ok; j++)
        if (keep[j] && too_close(ranked_boxes[i], ranked_boxes[j])) ok = 1'b0;
      keep = {keep, ok};
      if (ok) last_idx = i;
    end
    for (int i = 0; i < ranked_boxes.size(); i++) begin
      if (keep[i]) begin
        rec.data = '0;
        rec.data[gbs_pkg::BOX_W-1:0] = ranked_boxes[i];
        rec.last = (i == last_idx);
        rec.drop = set_overflow;
        kept_q = {kept_q, rec};
      end
    end
    ranked_boxes.delete();
    set_overflow = 1'b0;
  endtask

  // one item on the input side; valid drops on the following falling edge
  task automatic send_box(input gbs_pkg::box_t b, input bit is_last);
    repeat (pick_gap()) @(negedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(gbs_pkg::TDATA_W-gbs_pkg::BOX_W){1'b0}}, b};
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_box(b, is_last);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic gbs_pkg::box_t make_box(int unsigned cx, int unsigned cy);
    gbs_pkg::box_t b;
    b.x = gbs_pkg::COORD_BITS'(cx + $urandom_range(0, 40));
    b.y = gbs_pkg::COORD_BITS'(cy + $urandom_range(0, 40));
    b.w = gbs_pkg::SIZE_BITS'($urandom_range(1, 80));
    b.h = gbs_pkg::SIZE_BITS'($urandom_range(1, 80));
    b.score = 16'(int'($urandom_range(0, 32768)) - 16384);
    if ($urandom_range(0, 4) == 0) b.score = 16'($urandom_range(0, 3) * 4096);  // ties
    b.tag = 16'($urandom);
    return b;
  endfunction

  function automatic gbs_pkg::box_t noise_box();
    gbs_pkg::box_t b;
    b.x = gbs_pkg::COORD_BITS'($urandom);
    b.y = gbs_pkg::COORD_BITS'($urandom);
    b.w = gbs_pkg::SIZE_BITS'($urandom);
    b.h = gbs_pkg::SIZE_BITS'($urandom);
    b.score = 16'($urandom); b.tag = 16'($urandom);
    return b;
  endfunction

  function automatic gbs_pkg::box_t fixed_box(int x, int y, int w, int h, int s, int t);
    gbs_pkg::box_t b;
    b.x = gbs_pkg::COORD_BITS'(x);
    b.y = gbs_pkg::COORD_BITS'(y);
    b.w = gbs_pkg::SIZE_BITS'(w);
    b.h = gbs_pkg::SIZE_BITS'(h);
    b.score = 16'(s); b.tag = 16'(t);
    return b;
  endfunction

  // waits until the block is idle, then writes one threshold register
  task automatic write_threshold(input logic idx, input int unsigned val);
    wait (kept_q.size() == 0);
    // covers the scan of the remaining marks and the clear step
    repeat (80) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= gbs_pkg::CFG_W'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gbs_pkg::CFG_NUM) thr_num = val; else thr_den = val;
  endtask

  task automatic send_random_set(input int n, input bit noisy);
    int unsigned cx, cy;
    cx = $urandom_range(0, 4000);
    cy = $urandom_range(0, 4000);
    for (int i = 0; i < n; i++)
      send_box(noisy && $urandom_range(0, 2) == 0 ? noise_box() : make_box(cx, cy),
               i == n - 1);
  endtask

  task automatic test_extremes();
    send_box(fixed_box(0, 0, 4096, 4096, 16384, 16'h0000), 1'b0);
    send_box(fixed_box(4095, 4095, 1, 1, -16384, 16'hffff), 1'b0);
    send_box(fixed_box(10, 10, 0, 50, 16384, 16'h1234), 1'b0);       // zero width
    send_box(fixed_box(10, 10, 50, 0, 16384, 16'h4321), 1'b0);       // zero height
    send_box(fixed_box(0, 0, 8191, 8191, -32768, 16'haaaa), 1'b0);   // all size bits
    send_box(fixed_box(4095, 0, 8191, 1, 32767, 16'h5555), 1'b1);
    send_box(fixed_box(5, 5, 5, 5, 0, 16'h0001), 1'b1);              // single box set
  endtask

  task automatic test_overlap_and_ties();
    // identical boxes, overlapping shifted boxes, disjoint boxes, equal scores
    send_box(fixed_box(100, 100, 50, 50, 8000, 1), 1'b0);
    send_box(fixed_box(100, 100, 50, 50, 8000, 2), 1'b0);
    send_box(fixed_box(110, 100, 50, 50, 9000, 3), 1'b0);
    send_box(fixed_box(130, 100, 50, 50, 7000, 4), 1'b0);
    send_box(fixed_box(150, 100, 50, 50, 8000, 5), 1'b0);            // touches boxes 1 and 2, overlaps 3 and 4
    send_box(fixed_box(900, 900, 20, 20, 8000, 6), 1'b1);
  endtask

  task automatic test_thresholds();
    write_threshold(gbs_pkg::CFG_NUM, 0);      // any nonempty intersection suppresses
    test_overlap_and_ties();
    write_threshold(gbs_pkg::CFG_DEN, 0);      // nothing suppressed
    test_overlap_and_ties();
    write_threshold(gbs_pkg::CFG_NUM, 255);
    write_threshold(gbs_pkg::CFG_DEN, 1);
    test_overlap_and_ties();
    write_threshold(gbs_pkg::CFG_NUM, 1);
    write_threshold(gbs_pkg::CFG_DEN, 255);
    send_random_set(6, 1'b0);
    write_threshold(gbs_pkg::CFG_NUM, 2);
    write_threshold(gbs_pkg::CFG_DEN, 5);
  endtask

  task automatic test_store_full();
    // fills the store, then the last item of the set arrives and is itself dropped
    for (int i = 0; i < gbs_pkg::MAX_BOXES + 1; i++)
      send_box(make_box(3000, 100), i == gbs_pkg::MAX_BOXES);
  endtask

  task automatic test_output_backpressure();
    // long hold on the result side while more sets keep arriving
    send_random_set(5, 1'b0);
    hold_cycles = 600;
    send_random_set(4, 1'b0);
    send_random_set(3, 1'b0);
    wait (kept_q.size() == 0);     // sender waits for every result
    send_random_set(4, 1'b1);
  endtask

  task automatic test_random_sets();
    int sent;
    sent = 0;
    while (sent < 10) begin
      int n;
      n = $urandom_range(1, 8);
      if ($urandom_range(0, 3) == 0) begin
        wait (kept_q.size() == 0);
        repeat (40) @(negedge clk_i);
        write_threshold($urandom_range(0, 1) ? gbs_pkg::CFG_NUM : gbs_pkg::CFG_DEN,
                        $urandom_range(0, 255));
      end
      send_random_set(n, $urandom_range(0, 4) == 0);
      sent += n;
    end
  endtask

  // receiver ready with random stalls and an optional long hold
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker against the oldest expectation
  always @(posedge clk_i) begin
    kept_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (kept_q.size() == 0) begin
        report_mismatch("unexpected result", 128'(m_axis_tdata), '0);
      end else begin
        want = kept_q.pop_front();
        if (m_axis_tdata !== want.data)
          report_mismatch("tdata", 128'(m_axis_tdata), 128'(want.data));
        if (m_axis_tlast !== want.last)
          report_mismatch("tlast", 128'(m_axis_tlast), 128'(want.last));
        if (m_axis_tuser !== want.drop)
          report_mismatch("tuser", 128'(m_axis_tuser), 128'(want.drop));
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    test_extremes();
    test_overlap_and_ties();
    test_thresholds();
    test_store_full();
    test_output_backpressure();
    test_random_sets();
    wait (kept_q.size() == 0);
    repeat (200) @(negedge clk_i);
    if (n_errors == 0 && kept_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
